/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define MRO_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, disabled during reset.
`define MRO_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/mro_pkg.sv */
// Types, constants and the rounding function of the oscillator bank.
package mro_pkg;

    localparam int COEF_W = 18;
    localparam int PH_W   = 24;
    localparam int PROD_W = COEF_W + PH_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic signed [PH_W-1:0] PH_MAX = 24'sh7FFFFF;
    localparam logic signed [PH_W-1:0] PH_MIN = -24'sh800000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] s;
        logic signed [PH_W-1:0]   x;
        logic signed [PH_W-1:0]   y;
    } tone_t;

    typedef struct packed {
        logic  act;
        tone_t tone;
    } rot_out_t;

    // Round half up, drop 16 fraction bits, saturate to the phasor range.
    function automatic logic signed [PH_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W:0]    v;
        logic signed [ACC_W-16:0] q;
        logic signed [PH_W-1:0]   r;
        v = (ACC_W+1)'(acc) + (ACC_W+1)'(32768);
        q = v[ACC_W:16];
        if (q > (ACC_W-15)'(PH_MAX))
            r = PH_MAX;
        else if (q < (ACC_W-15)'(PH_MIN))
            r = PH_MIN;
        else
            r = q[PH_W-1:0];
        return r;
    endfunction

endpackage

/* hw/rtl/mro_cell.sv */
// One cell of the tone ring: holds one tone's coefficients and phasor.
module mro_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load_en,
    input  mro_pkg::tone_t load_data,
    input  logic          shift_en,
    input  mro_pkg::tone_t shift_in,
    output mro_pkg::tone_t tone_out
);
    import mro_pkg::*;

    tone_t tone_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_reg <= '0;
        end
        else if (load_en)
        begin
            tone_reg <= load_data;
        end
        else if (shift_en)
        begin
            tone_reg <= shift_in;
        end
    end

    assign tone_out = tone_reg;

endmodule

/* hw/rtl/mro_rotator.sv */
// Shared rotation slot of the ring: registered products, then round and saturate.
module mro_rotator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic             act_in,
    input  mro_pkg::tone_t   tone_in,
    output mro_pkg::rot_out_t rot_out
);
    import mro_pkg::*;

    logic signed [PROD_W-1:0] cx_reg;
    logic signed [PROD_W-1:0] sy_reg;
    logic signed [PROD_W-1:0] sx_reg;
    logic signed [PROD_W-1:0] cy_reg;
    tone_t                    hold_reg;
    logic                     act_reg;

    logic signed [ACC_W-1:0]  acc_x;
    logic signed [ACC_W-1:0]  acc_y;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            cx_reg   <= tone_in.c * tone_in.x;
            sy_reg   <= tone_in.s * tone_in.y;
            sx_reg   <= tone_in.s * tone_in.x;
            cy_reg   <= tone_in.c * tone_in.y;
            hold_reg <= tone_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            act_reg <= act_in;
        end
    end

    assign acc_x = ACC_W'(cx_reg) - ACC_W'(sy_reg);
    assign acc_y = ACC_W'(sx_reg) + ACC_W'(cy_reg);

    // Inactive tones pass through unchanged.
    always_comb
    begin
        rot_out.act    = act_reg;
        rot_out.tone.c = hold_reg.c;
        rot_out.tone.s = hold_reg.s;
        rot_out.tone.x = act_reg ? round_sat(acc_x) : hold_reg.x;
        rot_out.tone.y = act_reg ? round_sat(acc_y) : hold_reg.y;
    end

endmodule

/* hw/rtl/multitone_rotation_oscillator_top.sv */
// Top level of the coupled-form quadrature oscillator bank.
//
// Input channel (in_valid/in_stall): cmd 0 loads tone tone_index with its
// rotation coefficients and start phasor; cmd 1 is a sample tick. A load
// with an index past the bank is dropped. Output channel (out_valid/out_stall)
// carries one saturated sample per tick; loads produce nothing.
// cfg_we/cfg_data write active_tones; the user must do so while the block is
// idle, as the block does not enforce it. Values above TONES act as TONES.
// Tones sit in a ring of TONES cells plus one rotation slot. A tick circulates
// the ring once, one position per cycle, through the single shared rotation
// unit; the input stays stalled while the tick circulates and while its sample
// is posted, and the next request is taken once the block is back in idle.
// A load does not stall the input. A finished sample sits in the output
// register while the next request is accepted; a tick that finishes while
// the previous sample is still stalled waits in its final state until the
// output register frees.
// Reset clears all tone state, active_tones and the output valid.
module multitone_rotation_oscillator_top #(
    parameter int TONES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [2:0]  tone_index,
    input  logic signed [17:0] coef_cos,
    input  logic signed [17:0] coef_sin,
    input  logic signed [23:0] start_x,
    input  logic signed [23:0] start_y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [23:0] sample,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data
);
    import mro_pkg::*;

    localparam int CW = $clog2(TONES + 1);
    localparam int SW = PH_W + $clog2(TONES) + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        step_reg, step_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [PH_W-1:0] sample_reg, sample_next;
    logic [3:0]           active_reg;

    logic                 in_acc;
    logic                 load_acc;
    logic                 shift_en;
    logic [CW-1:0]        n_eff;
    tone_t                load_data;
    tone_t                cell_out [TONES];
    tone_t                cell_in  [TONES];
    rot_out_t             rot_out;
    logic signed [PH_W-1:0] sum_sat;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign load_acc = in_acc && (cmd == CMD_LOAD);
    assign shift_en = (state_reg == ST_RUN);

    assign n_eff = (32'(active_reg) > TONES) ? CW'(TONES) : CW'(active_reg);

    assign load_data.c = coef_cos;
    assign load_data.s = coef_sin;
    assign load_data.x = start_x;
    assign load_data.y = start_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (cfg_we)
        begin
            active_reg <= cfg_data;
        end
    end

    // Ring: cell k takes cell k+1, the last cell takes the rotation slot.
    genvar k;
    generate
        for (k = 0; k < TONES; k++)
        begin : g_cell
            if (k == TONES - 1)
            begin : g_tail
                assign cell_in[k] = rot_out.tone;
            end
            else
            begin : g_mid
                assign cell_in[k] = cell_out[k+1];
            end

            mro_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .load_en   (load_acc && (32'(tone_index) == k)),
                .load_data (load_data),
                .shift_en  (shift_en),
                .shift_in  (cell_in[k]),
                .tone_out  (cell_out[k])
            );
        end
    endgenerate

    mro_rotator u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .act_in   (step_reg < n_eff),
        .tone_in  (cell_out[0]),
        .rot_out  (rot_out)
    );

    always_comb
    begin
        if (sum_reg > SW'(PH_MAX))
            sum_sat = PH_MAX;
        else if (sum_reg < SW'(PH_MIN))
            sum_sat = PH_MIN;
        else
            sum_sat = sum_reg[PH_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (cmd == CMD_TICK))
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    sum_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (rot_out.act)
                    sum_next = sum_reg + SW'(rot_out.tone.y);
                step_next = step_reg + CW'(1);
                if (step_reg == CW'(TONES))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // Hold until the output register frees.
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    sample_next    = sum_sat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            sample_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            sample_reg    <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

/* hw/rtl/mro_checker.sv */
// Port-level checker for the oscillator bank, bound to the top level.
`include "assert_macros.svh"

module mro_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        cmd,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] sample
);
    import mro_pkg::*;

    // A stalled sample stays put.
    `MRO_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample))
    // After a load the input is free again in the next cycle.
    `MRO_ASSERT_NXT(a_load_quick, in_valid && !in_stall && (cmd == CMD_LOAD), !in_stall)
    // A tick keeps the input busy.
    `MRO_ASSERT_NXT(a_tick_busy, in_valid && !in_stall && (cmd == CMD_TICK), in_stall)
    // A new sample only comes out of a busy period.
    `MRO_ASSERT_IMP(a_out_source, $rose(out_valid), $past(in_stall))

endmodule

bind multitone_rotation_oscillator_top mro_checker u_mro_checker (.*);

/* tb/multitone_rotation_oscillator_top_test.sv */
// Self-checking testbench for the quadrature oscillator bank: loads, ticks, backpressure.
module multitone_rotation_oscillator_top_test;
    import mro_pkg::*;

    localparam int NTONES         = 8;
    localparam int SETTLE_CYCLES  = 2 * NTONES;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int REPORT_LIMIT   = 10;
    localparam real TWO_PI        = 6.283185307179586;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     cmd = CMD_LOAD;
    logic [2:0]               tone_index = '0;
    logic signed [COEF_W-1:0] coef_cos = '0;
    logic signed [COEF_W-1:0] coef_sin = '0;
    logic signed [PH_W-1:0]   start_x = '0;
    logic signed [PH_W-1:0]   start_y = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [PH_W-1:0]   out_sample;
    logic                     cfg_we = 1'b0;
    logic [3:0]               cfg_data = '0;

    // Handshake state captured mid-cycle, used at the following rising edge.
    logic                     in_accepted = 1'b0;
    logic                     out_accepted = 1'b0;
    logic signed [PH_W-1:0]   sample_seen = '0;

    int                       in_idle_pct = 0;
    int                       out_stall_pct = 0;
    int                       hold_cycles = 0;
    int                       quiet_cycles = 0;
    int                       mismatches = 0;

    // Expected bank state
    logic signed [COEF_W-1:0] tone_cos [NTONES];
    logic signed [COEF_W-1:0] tone_sin [NTONES];
    logic signed [PH_W-1:0]   tone_x [NTONES];
    logic signed [PH_W-1:0]   tone_y [NTONES];
    int unsigned              tones_on;
    logic signed [PH_W-1:0]   expected_samples [$];

    multitone_rotation_oscillator_top #(
        .TONES(NTONES)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .tone_index (tone_index),
        .coef_cos   (coef_cos),
        .coef_sin   (coef_sin),
        .start_x    (start_x),
        .start_y    (start_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample     (out_sample),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    always @(negedge clk)
    begin
        in_accepted  = rst_n && in_valid && !in_stall;
        out_accepted = rst_n && out_valid && !out_stall;
        sample_seen  = out_sample;
    end

    // Receiver: a long hold-off takes priority over random stalls.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    function automatic logic signed [PH_W-1:0] clamp_phasor(input longint v);
        if (v > longint'(PH_MAX))
            return PH_MAX;
        if (v < longint'(PH_MIN))
            return PH_MIN;
        return v[PH_W-1:0];
    endfunction

    // Round half up, drop the 16 fraction bits, then saturate to the phasor range.
    function automatic logic signed [PH_W-1:0] scale_down(input longint acc);
        return clamp_phasor((acc + 64'sd32768) >>> 16);
    endfunction

    task automatic note_mismatch(input string what, input logic signed [PH_W-1:0] want,
                                 input logic signed [PH_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch (%s): expected %0d, got %0d", what, want, got);
    endtask

    always @(posedge clk)
    begin
        if (out_accepted)
        begin
            if (expected_samples.size() == 0)
                note_mismatch("no sample pending", 'x, sample_seen);
            else if (expected_samples[0] !== sample_seen)
                note_mismatch("sample", expected_samples[0], sample_seen);
            if (expected_samples.size() != 0)
                void'(expected_samples.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || in_accepted || out_accepted)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** multitone_rotation_oscillator_top: FAILED **");
            $finish;
        end
    end

    // Advance the expected bank by one accepted request.
    task automatic advance_bank(input logic op, input logic [2:0] idx,
                                input logic signed [COEF_W-1:0] c, s,
                                input logic signed [PH_W-1:0] x, y);
        int unsigned n;
        longint      sum;
        logic signed [PH_W-1:0] nx, ny;
        if (op == CMD_LOAD)
        begin
            if (idx < NTONES)
            begin
                tone_cos[idx] = c;
                tone_sin[idx] = s;
                tone_x[idx]   = x;
                tone_y[idx]   = y;
            end
        end
        else
        begin
            n   = (tones_on > NTONES) ? NTONES : tones_on;
            sum = 0;
            for (int i = 0; i < n; i++)
            begin
                nx = scale_down(longint'(tone_cos[i]) * longint'(tone_x[i])
                              - longint'(tone_sin[i]) * longint'(tone_y[i]));
                ny = scale_down(longint'(tone_sin[i]) * longint'(tone_x[i])
                              + longint'(tone_cos[i]) * longint'(tone_y[i]));
                tone_x[i] = nx;
                tone_y[i] = ny;
                sum += longint'(ny);
            end
            expected_samples.push_back(clamp_phasor(sum));
        end
    endtask

    task automatic send_request(input logic op, input logic [2:0] idx,
                                input logic signed [COEF_W-1:0] c, s,
                                input logic signed [PH_W-1:0] x, y);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        tone_index <= idx;
        coef_cos   <= c;
        coef_sin   <= s;
        start_x    <= x;
        start_y    <= y;
        do
            @(posedge clk);
        while (!in_accepted);
        advance_bank(op, idx, c, s, x, y);
    endtask

    task automatic send_tick();
        send_request(CMD_TICK, 3'($urandom), 18'($urandom), 18'($urandom),
                     24'($urandom), 24'($urandom));
    endtask

    // Load a clean sinusoid: unit-gain rotation, bounded amplitude.
    task automatic load_sinusoid(input logic [2:0] idx);
        real step, phase, amp;
        step  = TWO_PI * $urandom_range(1, 12000) / 48000.0;
        phase = TWO_PI * $urandom_range(0, 9999) / 10000.0;
        amp   = $urandom_range(0, 1 << 20);
        send_request(CMD_LOAD, idx, 18'($rtoi(65536.0 * $cos(step))),
                     18'($rtoi(65536.0 * $sin(step))), 24'($rtoi(amp * $cos(phase))),
                     24'($rtoi(amp * $sin(phase))));
    endtask

    task automatic send_noise_load();
        send_request(CMD_LOAD, 3'($urandom), 18'($urandom), 18'($urandom),
                     24'($urandom), 24'($urandom));
    endtask

    // Wait until every sample is out and any trailing load has finished.
    task automatic settle_bank();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_active_tones(input logic [3:0] value);
        settle_bank();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tones_on = value;
    endtask

    // Change the idle rates mid-cycle, then return on a rising edge.
    task automatic set_idling(input int sender_pct, input int receiver_pct);
        @(negedge clk);
        in_idle_pct   = sender_pct;
        out_stall_pct = receiver_pct;
        @(posedge clk);
    endtask

    // Ticks with no tones active give zero and loads alone give nothing; then three tones run.
    task automatic test_empty_bank();
        send_tick();
        for (int i = 0; i < NTONES; i++)
            load_sinusoid(3'(i));
        send_tick();
        send_tick();
        write_active_tones(4'd0);
        send_tick();
        write_active_tones(4'd3);
        send_tick();
        send_tick();
    endtask

    // Extreme coefficients and phasors drive the components into saturation.
    task automatic test_field_extremes();
        send_request(CMD_LOAD, 3'd0, 18'sh1FFFF, -18'sh20000, PH_MAX, PH_MIN);
        send_request(CMD_LOAD, 3'd7, -18'sh20000, 18'sh1FFFF, PH_MIN, PH_MAX);
        send_request(CMD_LOAD, 3'd1, 18'sh10000, 18'sh00000, -24'sh000001, 24'sh000001);
        write_active_tones(4'd15);
        send_tick();
        send_tick();
        send_request(CMD_LOAD, 3'd7, 18'sh1FFFF, 18'sh1FFFF, PH_MAX, PH_MAX);
        send_tick();
        write_active_tones(4'd8);
        send_tick();
        send_tick();
    endtask

    // Hold the receiver off while ticks keep coming until the input stalls.
    task automatic test_backpressure();
        write_active_tones(4'd8);
        set_idling(0, 0);
        hold_cycles = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_tick();
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input logic [3:0] active, input int count);
        int pick;
        write_active_tones(active);
        set_idling(sender_pct, receiver_pct);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 64)
                send_tick();
            else if (pick < 85)
                load_sinusoid(3'($urandom));
            else
                send_noise_load();
        end
    endtask

    initial
    begin
        for (int i = 0; i < NTONES; i++)
        begin
            tone_cos[i] = '0;
            tone_sin[i] = '0;
            tone_x[i]   = '0;
            tone_y[i]   = '0;
        end
        tones_on = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_bank();
        test_field_extremes();
        test_backpressure();
        test_random_traffic(0, 0, 4'd8, 465);
        test_random_traffic(74, 0, 4'd15, 465);
        test_random_traffic(0, 74, 4'd4, 465);
        test_random_traffic(34, 34, 4'd1, 465);

        settle_bank();
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("** multitone_rotation_oscillator_top: PASSED **");
        else
            $display("** multitone_rotation_oscillator_top: FAILED **");
        $finish;
    end

endmodule
